### hw/rtl/dpq_pkg.sv
// Shared types and codes for the dynamic priority ready queue.
`default_nettype none

package dpq_pkg;

  typedef struct packed {
    logic               cmd;
    logic        [7:0]  proc_id;
    logic        [15:0] run_time;
    logic signed [15:0] prio_level;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic        [7:0]  ran_id;
    logic        [15:0] time_left;
    logic signed [15:0] new_prio;
    logic               finished;
    logic        [3:0]  occupancy;
  } out_item_t;

  // One stored process: id, remaining run time and current priority.
  typedef struct packed {
    logic        [7:0]  id;
    logic        [15:0] run;
    logic signed [15:0] prio;
  } entry_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_RAN   = 3'd3;
  localparam logic [2:0] ST_IDLE  = 3'd4;

  localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

endpackage

`default_nettype wire

### hw/rtl/dpq_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
`default_nettype none

interface dpq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/dpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/dynamic_priority_ready_queue.sv
// Priority ready queue with aging: sorted store in RAM, walked by a small sequencer.
//
// Input channel in_ch carries commands. An add command (cmd 0) inserts proc_id with
// run_time and prio_level ahead of every entry of lower or equal priority; it is
// rejected as full, or as zero run time, without touching the queue. A tick (cmd 1)
// pops the head, reports its id, lowers run time and priority by one (priority
// saturates at its minimum) and reinserts it unless its run time reached zero.
// Every command gives exactly one result on out_ch, with the occupancy after it.
//
// The queue is kept sorted in a RAM with one write and one registered read port.
// Each step of the insertion walk is a read, then a compare and write, and so is
// each step of the shift that closes the gap after a pop. Rejected commands and
// ticks on an empty queue go straight to the result step.
// One command is processed at a time; in_ch.ready is high only while the sequencer
// waits for a command. The result sits in an output register; a stalled receiver
// holds the sequencer in its final step until that register frees up.
// Synchronous reset empties the queue and drops any pending result. RAM contents
// are not cleared; only entries below the fill count are ever used.
`default_nettype none

module dynamic_priority_ready_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input wire logic     clk,
  input wire logic     rst_n,
  dpq_stream_if.sink   in_ch,
  dpq_stream_if.source out_ch
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EW    = $bits(dpq_pkg::entry_t);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CHK  = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_POP_WAIT = 3'd3;
  localparam logic [2:0] S_SHF_CHK  = 3'd4;
  localparam logic [2:0] S_SHF_WR   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  dpq_pkg::entry_t        ent_r, ent_nxt;
  dpq_pkg::out_item_t     res_r, res_nxt;
  dpq_pkg::out_item_t     out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  dpq_pkg::entry_t        ram_wdata;
  logic [EW-1:0]          ram_rdata;
  dpq_pkg::entry_t        rd_ent;

  logic [CNT_W-1:0]       k_m1;
  logic                   in_xfer;
  dpq_pkg::in_item_t      cmd_in;

  assign rd_ent  = dpq_pkg::entry_t'(ram_rdata);
  assign k_m1    = k_r - CNT_W'(1);
  assign cmd_in  = in_ch.data;
  assign in_xfer = in_ch.valid && (state_r == S_IDLE);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  dpq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    ent_nxt       = ent_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r[AW-1:0];
    ram_wdata     = ent_r;
    ram_raddr     = k_m1[AW-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_xfer) begin
          res_nxt           = '0;
          ent_nxt.id        = cmd_in.proc_id;
          ent_nxt.run       = cmd_in.run_time;
          ent_nxt.prio      = cmd_in.prio_level;
          k_nxt             = count_r;
          if (cmd_in.cmd == dpq_pkg::CMD_ADD) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              res_nxt.status = dpq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else if (cmd_in.run_time == '0) begin
              res_nxt.status = dpq_pkg::ST_ZERO;
              state_nxt      = S_DONE;
            end else begin
              res_nxt.status = dpq_pkg::ST_ADDED;
              state_nxt      = S_INS_CHK;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = dpq_pkg::ST_IDLE;
              state_nxt      = S_DONE;
            end else begin
              res_nxt.status = dpq_pkg::ST_RAN;
              state_nxt      = S_POP_WAIT;
            end
          end
        end
      end

      // Walk from the tail toward the head, moving lower or equal entries up one slot.
      S_INS_CHK: begin
        if (k_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_ent.prio > ent_r.prio) begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          ram_wdata = rd_ent;
          k_nxt     = k_m1;
          state_nxt = S_INS_CHK;
        end
      end

      S_POP_WAIT: begin
        ent_nxt = rd_ent;
        if (rd_ent.prio != dpq_pkg::PRIO_MIN) begin
          ent_nxt.prio = rd_ent.prio - 16'sd1;
        end
        if (rd_ent.run != '0) begin
          ent_nxt.run = rd_ent.run - 16'd1;
        end
        res_nxt.ran_id    = rd_ent.id;
        res_nxt.time_left = ent_nxt.run;
        res_nxt.new_prio  = ent_nxt.prio;
        res_nxt.finished  = (ent_nxt.run == '0);
        k_nxt             = CNT_W'(1);
        state_nxt         = S_SHF_CHK;
      end

      // Close the gap left by the head, one entry per read/write pair.
      S_SHF_CHK: begin
        ram_raddr = k_r[AW-1:0];
        if (k_r < count_r) begin
          state_nxt = S_SHF_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          k_nxt     = count_r - CNT_W'(1);
          if (res_r.finished) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_INS_CHK;
          end
        end
      end

      S_SHF_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_m1[AW-1:0];
        ram_wdata = rd_ent;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_SHF_CHK;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt           = res_r;
          out_nxt.occupancy = 4'(count_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    ent_r <= ent_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire
